// ----- hdl/cdq_pkg.sv -----
// cdq_pkg: shared types and constants of the circular double-ended queue
// operation, status and controller state codes, plus the command and status
// structs between controller and datapath; depends on nothing
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam int OP_W     = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_READ = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch the accepted item
        logic execute;    // apply the operation to indices and store
        logic load_read;  // move the store read data into the result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_read;  // latched op is a pop that will succeed
        logic res_busy;   // result register holds an item that is not taken
    } t_dp_sts;

endpackage

// ----- hdl/cdq_in_if.sv -----
// cdq_in_if: input channel of the deque, valid/ready with op and push word
// depends on cdq_pkg for field widths
interface cdq_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [cdq_pkg::OP_W-1:0]              op;
    logic signed [cdq_pkg::WORD_W-1:0]     push_word;

    modport source (output valid, output op, output push_word, input ready);
    modport sink   (input valid, input op, input push_word, output ready);
endinterface

// ----- hdl/cdq_out_if.sv -----
// cdq_out_if: result channel of the deque, valid/ready with popped word,
// status and occupancy; depends on cdq_pkg for field widths
interface cdq_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cdq_pkg::WORD_W-1:0]     popped_word;
    logic [cdq_pkg::STATUS_W-1:0]          status;
    logic [cdq_pkg::OCC_W-1:0]             occupancy;

    modport source (output valid, output popped_word, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input popped_word, input status, input occupancy,
                    output ready);
endinterface

// ----- hdl/cdq_ctrl.sv -----
// cdq_ctrl: sequencing state machine of the deque
// depends on cdq_pkg for state enum and command/status structs
module cdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cdq_pkg::t_dp_sts  i_sts,
    output cdq_pkg::t_dp_cmd  o_cmd
);

    cdq_pkg::t_state r_state;
    cdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cdq_pkg::S_EXEC;
                end
            end
            cdq_pkg::S_EXEC: begin
                // wait for the result register to drain
                if (!i_sts.res_busy) begin
                    n_state = i_sts.need_read ? cdq_pkg::S_READ : cdq_pkg::S_IDLE;
                end
            end
            cdq_pkg::S_READ: begin
                n_state = cdq_pkg::S_IDLE;
            end
            default: begin
                n_state = cdq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.capture     = 1'b0;
        o_cmd.execute     = 1'b0;
        o_cmd.load_read   = 1'b0;
        unique case (r_state)
            cdq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            cdq_pkg::S_EXEC: begin
                o_cmd.execute = !i_sts.res_busy;
            end
            cdq_pkg::S_READ: begin
                o_cmd.load_read = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    // a pending read always lands in an empty result register
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::S_READ) |-> !i_sts.res_busy)
        else $error("read completes while result register is occupied");

    // an accepted item is executed or waits, never dropped
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == cdq_pkg::S_EXEC))
        else $error("accepted item did not reach execute");

    // a pop that succeeds always goes through the read state
    a_exec_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.execute && i_sts.need_read) |=> o_cmd.load_read)
        else $error("successful pop skipped the store read");
`endif

endmodule

// ----- hdl/cdq_datapath.sv -----
// cdq_datapath: entry store, head/tail indices, count and result register
// depends on cdq_pkg for codes, widths and command/status structs
module cdq_datapath #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cdq_pkg::t_dp_cmd                   i_cmd,
    output cdq_pkg::t_dp_sts                   o_sts,
    input  logic [cdq_pkg::OP_W-1:0]           i_op,
    input  logic signed [cdq_pkg::WORD_W-1:0]  i_push_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [cdq_pkg::WORD_W-1:0]  o_popped_word,
    output logic [cdq_pkg::STATUS_W-1:0]       o_status,
    output logic [cdq_pkg::OCC_W-1:0]          o_occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > cdq_pkg::OCC_W) ? CW : cdq_pkg::OCC_W;
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    // entry store, no reset: an entry is read only after it was written
    logic [cdq_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [cdq_pkg::WORD_W-1:0] r_rd_data;

    cdq_pkg::t_op               r_op;
    logic [cdq_pkg::WORD_W-1:0] r_word;

    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [IW-1:0] n_head;
    logic [IW-1:0] n_tail;
    logic [CW-1:0] n_count;

    logic                        r_out_valid;
    logic [cdq_pkg::WORD_W-1:0]  r_res_word;
    cdq_pkg::t_status            r_res_status;
    logic [cdq_pkg::OCC_W-1:0]   r_res_occ;

    cdq_pkg::t_status w_status;
    logic             w_wr_en;
    logic [IW-1:0]    w_wr_addr;
    logic             w_rd_en;
    logic [IW-1:0]    w_rd_addr;
    logic             w_full;
    logic             w_empty;
    logic             w_is_pop;
    logic [IW-1:0]    w_head_prev;
    logic [IW-1:0]    w_head_next;
    logic [IW-1:0]    w_tail_prev;
    logic [IW-1:0]    w_tail_next;
    logic [OW-1:0]    w_occ_wide;
    logic [OW-1:0]    w_cnt_wide;

    assign w_full      = (r_count == CNT_FULL);
    assign w_empty     = (r_count == '0);
    assign w_is_pop    = (r_op == cdq_pkg::OP_POP_FRONT) || (r_op == cdq_pkg::OP_POP_BACK);
    assign w_head_prev = (r_head == '0) ? IDX_LAST : r_head - 1'b1;
    assign w_head_next = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
    assign w_tail_prev = (r_tail == '0) ? IDX_LAST : r_tail - 1'b1;
    assign w_tail_next = (r_tail == IDX_LAST) ? '0 : r_tail + 1'b1;
    assign w_occ_wide  = OW'(n_count);
    assign w_cnt_wide  = OW'(r_count);

    assign o_sts.need_read = w_is_pop && !w_empty;
    assign o_sts.res_busy  = r_out_valid && !i_out_ready;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        w_status  = cdq_pkg::ST_DONE;
        w_wr_en   = 1'b0;
        w_wr_addr = r_tail;
        w_rd_en   = 1'b0;
        w_rd_addr = r_head;
        unique case (r_op)
            cdq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = cdq_pkg::ST_FULL;
                end else begin
                    n_head    = w_head_prev;
                    n_count   = r_count + 1'b1;
                    w_wr_en   = i_cmd.execute;
                    w_wr_addr = w_head_prev;
                end
            end
            cdq_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = cdq_pkg::ST_FULL;
                end else begin
                    n_tail    = w_tail_next;
                    n_count   = r_count + 1'b1;
                    w_wr_en   = i_cmd.execute;
                    w_wr_addr = r_tail;
                end
            end
            cdq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    w_status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_head    = w_head_next;
                    n_count   = r_count - 1'b1;
                    w_rd_en   = i_cmd.execute;
                    w_rd_addr = r_head;
                end
            end
            cdq_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = cdq_pkg::ST_EMPTY;
                end else begin
                    n_tail    = w_tail_prev;
                    n_count   = r_count - 1'b1;
                    w_rd_en   = i_cmd.execute;
                    w_rd_addr = w_tail_prev;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_word;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= cdq_pkg::t_op'(i_op);
            r_word <= i_push_word;
        end
        if (i_cmd.execute) begin
            r_res_word   <= '0;
            r_res_status <= w_status;
            r_res_occ    <= w_occ_wide[cdq_pkg::OCC_W-1:0];
        end
        if (i_cmd.load_read) begin
            r_res_word <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            priority if (i_cmd.execute && !o_sts.need_read) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.load_read) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_popped_word = r_res_word;
    assign o_status      = r_res_status;
    assign o_occupancy   = r_res_occ;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count above depth");

    // empty and full both leave head and tail on the same slot
    a_index_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_FULL) |-> (r_head == r_tail))
        else $error("head and tail apart on empty or full store");

    // a refused item moves neither index nor the count
    a_refuse_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && w_status != cdq_pkg::ST_DONE) |=>
            ($stable(r_count) && $stable(r_head) && $stable(r_tail)))
        else $error("refused item moved an index or the count");

    // a shown result carries the current occupancy
    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res_occ == w_cnt_wide[cdq_pkg::OCC_W-1:0]))
        else $error("result occupancy differs from entry count");
`endif

endmodule

// ----- hdl/circular_double_ended_queue_core.sv -----
// circular_double_ended_queue_core: top level of the circular deque
// joins cdq_ctrl and cdq_datapath; uses cdq_pkg, cdq_in_if and cdq_out_if
//
// usage
//   i_in carries one item per operation: op (push front, push back, pop front,
//   pop back) and push_word. o_out returns one result per item: the popped
//   word (zero for pushes and refused items), a status (done, full, empty)
//   and the occupancy after the operation.
//   items are taken one at a time. a push or a refused item shows its result
//   once the execute state has updated the result register; a pop that
//   succeeds also passes through the read state, since the store is a memory
//   with a registered read port and the read data is loaded into the result
//   there. the next item is accepted in the first cycle the result is shown.
//   the result sits in an output register: the next item is accepted while a
//   result waits, and it is held in execute until the receiver takes the
//   waiting result; a stalled receiver thus stalls the input after one item.
//   reset clears head, tail, count and the result valid; the store keeps its
//   contents and needs no clearing pass, as an entry is read only after it
//   was written.
module circular_double_ended_queue_core #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdq_in_if.sink      i_in,
    cdq_out_if.source   o_out
);

    cdq_pkg::t_dp_cmd w_cmd;
    cdq_pkg::t_dp_sts w_sts;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_in.op),
        .i_push_word   (i_in.push_word),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_popped_word (o_out.popped_word),
        .o_status      (o_out.status),
        .o_occupancy   (o_out.occupancy)
    );

endmodule
